// ----- src/fcfe_pkg.sv -----
// Shared types, constants and helper functions of the current feedback front end.
`timescale 1ns / 1ps

package fcfe_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_ALPHA = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENC_ZERO     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLE_CNT     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE_DIR  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_TURN    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_USE_ENCODER  = 3'd5;

    localparam logic [14:0] RST_FILTER_ALPHA = 15'd16384;
    localparam logic [6:0]  RST_POLE_CNT     = 7'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_REC, ST_LAG, ST_CLA, ST_CLB,
        ST_SA, ST_SB, ST_SC, ST_SD,
        ST_CA, ST_CB, ST_CC, ST_CD, ST_CR,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5
    } t_state;

    typedef enum logic [1:0] {
        REC_RAW,
        REC_NEG,
        REC_SUM
    } t_rec_mode;

    typedef enum logic [1:0] {
        PH_U,
        PH_V,
        PH_W
    } t_phase;

    typedef struct packed {
        logic load;
        logic update;
    } t_lane_ctl;

    typedef struct packed {
        logic [14:0] filter_alpha;
        logic [15:0] enc_zero;
        logic [6:0]  pole_cnt;
        logic        reverse_dir;
        logic        half_turn_offset;
        logic        use_encoder;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] i_alpha;
        logic signed [15:0] i_beta;
        logic signed [15:0] i_d;
        logic signed [15:0] i_q;
        logic [15:0]        elec_angle;
    } t_result;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) begin
            return 16'sh7FFF;
        end
        if (v < -40'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Decides how a phase is rebuilt from the samples in a given sector.
    function automatic t_rec_mode rec_mode(input t_phase phase, input logic [2:0] sector);
        t_phase sum_phase;
        logic   raw;
        sum_phase = PH_U;
        raw       = 1'b0;
        unique case (sector)
            3'd1, 3'd6: sum_phase = PH_U;
            3'd2, 3'd3: sum_phase = PH_V;
            3'd4, 3'd5: sum_phase = PH_W;
            default:    raw = 1'b1;
        endcase
        if (raw) begin
            return REC_RAW;
        end
        return (phase == sum_phase) ? REC_SUM : REC_NEG;
    endfunction

endpackage

// ----- src/fcfe_if.sv -----
// Handshake interfaces for the sample, result and configuration channels.
`timescale 1ns / 1ps

interface fcfe_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cur_u;
    logic signed [15:0] cur_v;
    logic signed [15:0] cur_w;
    logic [2:0]         pwm_sector;
    logic [15:0]        mech_angle;

    modport source(output valid, cur_u, cur_v, cur_w, pwm_sector, mech_angle, input ready);
    modport sink(input valid, cur_u, cur_v, cur_w, pwm_sector, mech_angle, output ready);
endinterface

interface fcfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] i_alpha;
    logic signed [15:0] i_beta;
    logic signed [15:0] i_d;
    logic signed [15:0] i_q;
    logic [15:0]        elec_angle;

    modport source(output valid, i_alpha, i_beta, i_d, i_q, elec_angle, input ready);
    modport sink(input valid, i_alpha, i_beta, i_d, i_q, elec_angle, output ready);
endinterface

interface fcfe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fcfe_pkg::CFG_ADDR_W-1:0] addr;
    logic [fcfe_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface

// ----- src/fcfe_lane.sv -----
// One phase lane: sector reconstruction followed by the first-order lag filter.
`timescale 1ns / 1ps

module fcfe_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fcfe_pkg::t_lane_ctl i_ctl,
    input  fcfe_pkg::t_rec_mode i_mode,
    input  logic signed [15:0]  i_own,
    input  logic signed [16:0]  i_pair_sum,
    input  logic [14:0]         i_alpha,
    output logic signed [15:0]  o_lag
);

    logic signed [15:0] r_rec;
    logic signed [15:0] n_rec;
    logic signed [15:0] r_y;
    logic signed [15:0] n_y;
    logic signed [16:0] diff;
    logic signed [31:0] prod;
    logic signed [31:0] step;

    always_comb begin
        unique case (i_mode)
            fcfe_pkg::REC_RAW: n_rec = i_own;
            fcfe_pkg::REC_NEG: n_rec = fcfe_pkg::sat16(-40'(i_own));
            fcfe_pkg::REC_SUM: n_rec = fcfe_pkg::sat16(40'(i_pair_sum));
            default:           n_rec = i_own;
        endcase
    end

    always_comb begin
        diff = 17'(r_rec) - 17'(r_y);
        prod = signed'({17'b0, i_alpha}) * 32'(diff);
        step = (prod + 32'sd16384) >>> 15;
        n_y  = fcfe_pkg::sat16(40'(r_y) + 40'(step));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rec <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y <= '0;
        end else if (i_ctl.update) begin
            r_y <= n_y;
        end
    end

    assign o_lag = r_y;

endmodule

// ----- src/fcfe_merge.sv -----
// Sequencer and merging stage: angle, Clarke, sine and Park on one shared multiplier.
`timescale 1ns / 1ps

module fcfe_merge #(
    parameter int SINE_TABLE_BITS = fcfe_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0]         i_mech,
    input  fcfe_pkg::t_cfg      i_cfg,
    input  logic signed [15:0]  i_lag_u,
    input  logic signed [15:0]  i_lag_v,
    input  logic signed [15:0]  i_lag_w,
    output fcfe_pkg::t_lane_ctl o_lane_ctl,
    output logic                o_idle,
    output logic                o_valid,
    input  logic                i_ready,
    output fcfe_pkg::t_result   o_result
);

    localparam logic [15:0] ANG_MASK = ~16'((32'd1 << (16 - SINE_TABLE_BITS)) - 32'd1);

    fcfe_pkg::t_state   r_state;
    fcfe_pkg::t_state   n_state;
    logic               mul_en;
    logic               out_load;
    logic signed [19:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [39:0] mul_p;
    logic signed [39:0] r_prod;

    logic [15:0]        r_ang;
    logic [15:0]        r_held;
    logic [14:0]        r_zs;
    logic [14:0]        r_zc;
    logic               r_sgn_s;
    logic               r_sgn_c;
    logic [14:0]        r_z2;
    logic signed [15:0] r_ia;
    logic signed [15:0] r_ib;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;
    logic signed [31:0] r_acc;
    logic signed [15:0] r_id;
    logic               r_out_valid;
    fcfe_pkg::t_result  r_out;

    logic [15:0]        mech_diff;
    logic [15:0]        ang_rev;
    logic [15:0]        ang_new;
    logic [15:0]        ang_s;
    logic [15:0]        ang_c;
    logic signed [18:0] clarke_s;
    logic signed [19:0] clarke_m;
    logic signed [16:0] diff_vw;
    logic [14:0]        prod_sh14;
    logic [14:0]        inner;
    logic [14:0]        mid;
    logic [16:0]        s_raw;
    logic [15:0]        s_cap;
    logic               sgn_now;
    logic signed [15:0] sine_val;
    logic signed [15:0] ia_new;
    logic signed [15:0] ib_new;
    logic signed [15:0] id_new;
    logic signed [15:0] iq_new;

    always_comb begin
        mech_diff = i_mech - i_cfg.enc_zero;
        ang_rev   = i_cfg.reverse_dir ? 16'(16'd0 - r_prod[15:0]) : r_prod[15:0];
        ang_new   = i_cfg.half_turn_offset ? (ang_rev ^ 16'h8000) : ang_rev;
        ang_s     = r_ang & ANG_MASK;
        ang_c     = ang_s + 16'h4000;
        clarke_s  = 19'(i_lag_u) + 19'(i_lag_u) - 19'(i_lag_v) - 19'(i_lag_w);
        // Offset by whole thirds so the reciprocal multiply sees a positive value.
        clarke_m  = 20'(clarke_s) + 20'sd196609;
        diff_vw   = 17'(i_lag_v) - 17'(i_lag_w);
        prod_sh14 = r_prod[28:14];
        inner     = 15'd10583 - prod_sh14;
        mid       = 15'd25736 - prod_sh14;
        s_raw     = r_prod[29:13];
        s_cap     = (s_raw > 17'd32767) ? 16'd32767 : s_raw[15:0];
        sgn_now   = (r_state == fcfe_pkg::ST_CR) ? r_sgn_c : r_sgn_s;
        sine_val  = sgn_now ? -signed'(s_cap) : signed'(s_cap);
        ia_new    = fcfe_pkg::sat16(40'(signed'({3'b0, r_prod[36:19]})) - 40'sd65536);
        ib_new    = fcfe_pkg::sat16((r_prod + 40'sd32768) >>> 16);
        id_new    = fcfe_pkg::sat16((40'(r_acc) + r_prod + 40'sd16384) >>> 15);
        iq_new    = fcfe_pkg::sat16((40'(r_acc) - r_prod + 40'sd16384) >>> 15);
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state    = r_state;
        o_lane_ctl = '0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        unique case (r_state)
            fcfe_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = fcfe_pkg::ST_REC;
                end
            end
            fcfe_pkg::ST_REC: begin
                o_lane_ctl.load = 1'b1;
                mul_en  = 1'b1;
                mul_a   = signed'({4'b0, mech_diff});
                mul_b   = signed'({13'b0, i_cfg.pole_cnt});
                n_state = fcfe_pkg::ST_LAG;
            end
            fcfe_pkg::ST_LAG: begin
                o_lane_ctl.update = 1'b1;
                n_state = fcfe_pkg::ST_CLA;
            end
            fcfe_pkg::ST_CLA: begin
                mul_en  = 1'b1;
                mul_a   = clarke_m;
                mul_b   = 20'sd174763;
                n_state = fcfe_pkg::ST_CLB;
            end
            fcfe_pkg::ST_CLB: begin
                mul_en  = 1'b1;
                mul_a   = 20'(diff_vw);
                mul_b   = 20'sd37837;
                n_state = fcfe_pkg::ST_SA;
            end
            fcfe_pkg::ST_SA: begin
                mul_en  = 1'b1;
                mul_a   = signed'({5'b0, r_zs});
                mul_b   = signed'({5'b0, r_zs});
                n_state = fcfe_pkg::ST_SB;
            end
            fcfe_pkg::ST_SB, fcfe_pkg::ST_CB: begin
                mul_en  = 1'b1;
                mul_a   = signed'({5'b0, prod_sh14});
                mul_b   = 20'sd1306;
                n_state = (r_state == fcfe_pkg::ST_SB) ? fcfe_pkg::ST_SC : fcfe_pkg::ST_CC;
            end
            fcfe_pkg::ST_SC, fcfe_pkg::ST_CC: begin
                mul_en  = 1'b1;
                mul_a   = signed'({5'b0, r_z2});
                mul_b   = signed'({5'b0, inner});
                n_state = (r_state == fcfe_pkg::ST_SC) ? fcfe_pkg::ST_SD : fcfe_pkg::ST_CD;
            end
            fcfe_pkg::ST_SD: begin
                mul_en  = 1'b1;
                mul_a   = signed'({5'b0, r_zs});
                mul_b   = signed'({5'b0, mid});
                n_state = fcfe_pkg::ST_CA;
            end
            fcfe_pkg::ST_CA: begin
                mul_en  = 1'b1;
                mul_a   = signed'({5'b0, r_zc});
                mul_b   = signed'({5'b0, r_zc});
                n_state = fcfe_pkg::ST_CB;
            end
            fcfe_pkg::ST_CD: begin
                mul_en  = 1'b1;
                mul_a   = signed'({5'b0, r_zc});
                mul_b   = signed'({5'b0, mid});
                n_state = fcfe_pkg::ST_CR;
            end
            fcfe_pkg::ST_CR: begin
                n_state = fcfe_pkg::ST_P1;
            end
            fcfe_pkg::ST_P1: begin
                mul_en  = 1'b1;
                mul_a   = 20'(r_ia);
                mul_b   = 20'(r_cos);
                n_state = fcfe_pkg::ST_P2;
            end
            fcfe_pkg::ST_P2: begin
                mul_en  = 1'b1;
                mul_a   = 20'(r_ib);
                mul_b   = 20'(r_sin);
                n_state = fcfe_pkg::ST_P3;
            end
            fcfe_pkg::ST_P3: begin
                mul_en  = 1'b1;
                mul_a   = 20'(r_ib);
                mul_b   = 20'(r_cos);
                n_state = fcfe_pkg::ST_P4;
            end
            fcfe_pkg::ST_P4: begin
                mul_en  = 1'b1;
                mul_a   = 20'(r_ia);
                mul_b   = 20'(r_sin);
                n_state = fcfe_pkg::ST_P5;
            end
            fcfe_pkg::ST_P5: begin
                if (!r_out_valid || i_ready) begin
                    out_load = 1'b1;
                    n_state  = fcfe_pkg::ST_IDLE;
                end
            end
            default: n_state = fcfe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (r_state == fcfe_pkg::ST_LAG && i_cfg.use_encoder) begin
            r_held <= ang_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        unique case (r_state)
            fcfe_pkg::ST_LAG: r_ang <= i_cfg.use_encoder ? ang_new : r_held;
            fcfe_pkg::ST_CLA: begin
                r_zs    <= ang_s[14] ? 15'(15'd16384 - {1'b0, ang_s[13:0]})
                                     : {1'b0, ang_s[13:0]};
                r_zc    <= ang_c[14] ? 15'(15'd16384 - {1'b0, ang_c[13:0]})
                                     : {1'b0, ang_c[13:0]};
                r_sgn_s <= ang_s[15];
                r_sgn_c <= ang_c[15];
            end
            fcfe_pkg::ST_CLB: r_ia <= ia_new;
            fcfe_pkg::ST_SA:  r_ib <= ib_new;
            fcfe_pkg::ST_SB, fcfe_pkg::ST_CB: r_z2 <= prod_sh14;
            fcfe_pkg::ST_CA:  r_sin <= sine_val;
            fcfe_pkg::ST_CR:  r_cos <= sine_val;
            fcfe_pkg::ST_P2, fcfe_pkg::ST_P4: r_acc <= r_prod[31:0];
            fcfe_pkg::ST_P3:  r_id <= id_new;
            default: begin
            end
        endcase
        if (out_load) begin
            r_out.i_alpha    <= r_ia;
            r_out.i_beta     <= r_ib;
            r_out.i_d        <= r_id;
            r_out.i_q        <= iq_new;
            r_out.elec_angle <= r_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_idle   = (r_state == fcfe_pkg::ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- src/foc_current_feedback_frontend_top.sv -----
// Top level of the current feedback front end: registers, sample capture, lanes and merge.
`timescale 1ns / 1ps

// One word of three phase samples, sector and encoder angle yields one word of alpha/beta,
// d/q currents and the electrical angle. The three phase lanes rebuild and filter their
// phase in parallel, then a sequencer drives a single shared multiplier through the angle,
// Clarke, sine, cosine and Park products; that chain of dependent products sets the rate.
// A word is accepted only while the sequencer is idle, so the next word is taken once the
// last has reached the result register. The result register lets a new word start
// while the last result waits; if it is still unread when the next finishes, the sequencer
// waits for it. Configuration writes are always taken and must only be made while idle.

module foc_current_feedback_frontend_top #(
    parameter int SINE_TABLE_BITS = fcfe_pkg::SINE_TABLE_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    fcfe_in_if.sink    i_in,
    fcfe_out_if.source o_out,
    fcfe_cfg_if.sink   i_cfg
);

    fcfe_pkg::t_cfg      r_cfg;
    fcfe_pkg::t_lane_ctl lane_ctl;
    fcfe_pkg::t_result   result;
    logic                idle;
    logic                in_acc;
    logic signed [15:0]  r_u;
    logic signed [15:0]  r_v;
    logic signed [15:0]  r_w;
    logic [2:0]          r_sector;
    logic [15:0]         r_mech;
    logic signed [15:0]  lag_u;
    logic signed [15:0]  lag_v;
    logic signed [15:0]  lag_w;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = idle;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_alpha     <= fcfe_pkg::RST_FILTER_ALPHA;
            r_cfg.enc_zero         <= '0;
            r_cfg.pole_cnt         <= fcfe_pkg::RST_POLE_CNT;
            r_cfg.reverse_dir      <= 1'b0;
            r_cfg.half_turn_offset <= 1'b0;
            r_cfg.use_encoder      <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                fcfe_pkg::CFG_FILTER_ALPHA: r_cfg.filter_alpha     <= i_cfg.data[14:0];
                fcfe_pkg::CFG_ENC_ZERO:     r_cfg.enc_zero         <= i_cfg.data;
                fcfe_pkg::CFG_POLE_CNT:     r_cfg.pole_cnt         <= i_cfg.data[6:0];
                fcfe_pkg::CFG_REVERSE_DIR:  r_cfg.reverse_dir      <= i_cfg.data[0];
                fcfe_pkg::CFG_HALF_TURN:    r_cfg.half_turn_offset <= i_cfg.data[0];
                fcfe_pkg::CFG_USE_ENCODER:  r_cfg.use_encoder      <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_u      <= i_in.cur_u;
            r_v      <= i_in.cur_v;
            r_w      <= i_in.cur_w;
            r_sector <= i_in.pwm_sector;
            r_mech   <= i_in.mech_angle;
        end
    end

    fcfe_lane u_lane_u (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_mode     (fcfe_pkg::rec_mode(fcfe_pkg::PH_U, r_sector)),
        .i_own      (r_u),
        .i_pair_sum (17'(r_v) + 17'(r_w)),
        .i_alpha    (r_cfg.filter_alpha),
        .o_lag      (lag_u)
    );

    fcfe_lane u_lane_v (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_mode     (fcfe_pkg::rec_mode(fcfe_pkg::PH_V, r_sector)),
        .i_own      (r_v),
        .i_pair_sum (17'(r_u) + 17'(r_w)),
        .i_alpha    (r_cfg.filter_alpha),
        .o_lag      (lag_v)
    );

    fcfe_lane u_lane_w (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_mode     (fcfe_pkg::rec_mode(fcfe_pkg::PH_W, r_sector)),
        .i_own      (r_w),
        .i_pair_sum (17'(r_u) + 17'(r_v)),
        .i_alpha    (r_cfg.filter_alpha),
        .o_lag      (lag_w)
    );

    fcfe_merge #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_mech     (r_mech),
        .i_cfg      (r_cfg),
        .i_lag_u    (lag_u),
        .i_lag_v    (lag_v),
        .i_lag_w    (lag_w),
        .o_lane_ctl (lane_ctl),
        .o_idle     (idle),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_result   (result)
    );

    assign o_out.i_alpha    = result.i_alpha;
    assign o_out.i_beta     = result.i_beta;
    assign o_out.i_d        = result.i_d;
    assign o_out.i_q        = result.i_q;
    assign o_out.elec_angle = result.elec_angle;

endmodule

// ----- src/fcfe_checker.sv -----
// Port-level checks of the front end and the bind that attaches them to the top level.
`timescale 1ns / 1ps

module fcfe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word withdrawn before it was taken");

    // Only one word is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again straight after a word was accepted");

    // A result never appears in the cycle right after a word is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // Reset leaves the block empty and ready for a word.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not empty and ready after reset");

endmodule

bind foc_current_feedback_frontend_top fcfe_checker u_fcfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
